FILE: rtl/core/ordered_list_engine_macros.svh
// assertion macros used by the ordered list engine rtl
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define OLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/ole_pkg.sv
// shared types and constants of the ordered list engine
`default_nettype none

package ole_pkg;

    // default geometry of the list
    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    // command codes
    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_APPEND     = 3'd2,
        CMD_REMOVE_AT  = 3'd3,
        CMD_REMOVE_VAL = 3'd4,
        CMD_POP        = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOB      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // what every cell does in the update cycle
    typedef enum logic [1:0] {
        CELL_HOLD        = 2'd0,
        CELL_OPEN        = 2'd1,
        CELL_CLOSE       = 2'd2,
        CELL_CLOSE_MATCH = 2'd3
    } cell_mode_t;

    // engine sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/ole_cell.sv
// one list slot: holds an entry and shifts it to or from its neighbours
`default_nettype none

module ole_cell
    import ole_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter int CNTW  = $clog2(DEPTH_DEF + 1),
    parameter int INDEX = 0
)
(
    input  wire              clk,
    input  cell_mode_t       mode,
    input  wire [CNTW-1:0]   at,
    input  wire [CNTW-1:0]   count,
    input  wire [CNTW-1:0]   pos,
    input  wire [WIDTH-1:0]  value,
    input  wire [WIDTH-1:0]  left_data,
    input  wire [WIDTH-1:0]  right_data,
    input  wire              found_in,
    input  wire [WIDTH-1:0]  rd_in,
    output logic             found_out,
    output logic [WIDTH-1:0] rd_out,
    output logic [WIDTH-1:0] data
);

    localparam logic [CNTW-1:0] IDX = CNTW'(INDEX);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic             match;

    // value match on a live slot, folded into the first-match chain
    assign match     = (data_reg == value) && (IDX < count);
    assign found_out = found_in | match;

    // positional read travels along the chain as an or of the hit slot
    assign rd_out = rd_in | ((IDX == pos) ? data_reg : '0);
    assign data   = data_reg;

    // next slot contents
    always_comb
    begin
        data_next = data_reg;
        case (mode)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_OPEN:
            begin
                if (IDX == at)
                begin
                    data_next = value;
                end
                else if (IDX > at)
                begin
                    data_next = left_data;
                end
            end
            CELL_CLOSE:
            begin
                if (IDX >= at)
                begin
                    data_next = right_data;
                end
            end
            CELL_CLOSE_MATCH:
            begin
                if (found_out)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // slot register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/ordered_list_engine.sv
// ordered list engine top level: sequencer, entry count and the row of slots
//
// A bounded ordered list of up to DEPTH values of WIDTH bits each.
// Commands: read at a position, insert at a position, append at the tail,
// remove at a position, remove the first entry equal to a value, pop front.
// Command channel: a beat is taken at a rising edge with start high and
// busy low; command, position and value are captured at that edge.
// Result channel: done is high for exactly one cycle and read_value,
// status, entry_count and list_empty are valid in that cycle only; the
// receiver cannot stall, so the result must be taken when it appears.
// Sequence: the cycle after acceptance runs the update across the row of
// slots (shifts, value compare, first-match chain); the cycle after that
// presents the registered result with done high. No new command is taken
// during the update; busy is high for the update cycle only, so start may
// be raised again in the cycle that shows done.
// A failed command leaves the list and the count unchanged.
// Reset: rst_n clears the count and the sequencer; slot contents are not
// cleared, as only positions below the count are ever read.
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire [2:0]                       command,
    input  wire [$clog2(DEPTH + 1)-1:0]     position,
    input  wire [WIDTH-1:0]                 value,
    output logic                            busy,
    output logic                            done,
    output logic [WIDTH-1:0]                read_value,
    output logic [2:0]                      status,
    output logic [$clog2(DEPTH + 1)-1:0]    entry_count,
    output logic                            list_empty
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);

    state_t           state_reg;
    state_t           state_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             done_reg;
    cmd_t             cmd_reg;
    logic [CNTW-1:0]  pos_reg;
    logic [WIDTH-1:0] val_reg;
    logic [WIDTH-1:0] rd_reg;
    logic [WIDTH-1:0] rd_next;
    status_t          st_reg;
    status_t          st_next;

    cell_mode_t       mode;
    logic [CNTW-1:0]  at;
    logic             accept;

    logic [WIDTH-1:0] data_w  [DEPTH];
    logic             found_w [DEPTH + 1];
    logic [WIDTH-1:0] rd_w    [DEPTH + 1];

    assign accept = start && (state_reg == ST_IDLE);

    // chain ends
    assign found_w[0] = 1'b0;
    assign rd_w[0]    = '0;

    // row of slots, each fed by its neighbours
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WIDTH-1:0] left_d;
        logic [WIDTH-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = data_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = data_w[g];
        end
        else
        begin : g_mid_r
            assign right_d = data_w[g+1];
        end

        ole_cell #(
            .WIDTH (WIDTH),
            .CNTW  (CNTW),
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .mode       (mode),
            .at         (at),
            .count      (count_reg),
            .pos        (pos_reg),
            .value      (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .found_in   (found_w[g]),
            .rd_in      (rd_w[g]),
            .found_out  (found_w[g+1]),
            .rd_out     (rd_w[g+1]),
            .data       (data_w[g])
        );
    end

    // sequencer, status decisions and slot control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mode       = CELL_HOLD;
        at         = pos_reg;
        st_next    = ST_OK;
        rd_next    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (cmd_reg)
                    CMD_READ:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            rd_next = rd_w[DEPTH];
                        end
                        else
                        begin
                            st_next = ST_OOB;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (pos_reg > count_reg)
                        begin
                            st_next = ST_OOB;
                        end
                        else if (count_reg == FULL_COUNT)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mode       = CELL_OPEN;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_APPEND:
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mode       = CELL_OPEN;
                            at         = count_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE_AT:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (pos_reg >= count_reg)
                        begin
                            st_next = ST_OOB;
                        end
                        else
                        begin
                            mode       = CELL_CLOSE;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_REMOVE_VAL:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (found_w[DEPTH])
                        begin
                            mode       = CELL_CLOSE_MATCH;
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                    CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            mode       = CELL_CLOSE;
                            at         = '0;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            rd_reg <= rd_next;
            st_reg <= st_next;
        end
    end

    // result beat
    assign busy        = (state_reg == ST_EXEC);
    assign done        = done_reg;
    assign read_value  = rd_reg;
    assign status      = st_reg;
    assign entry_count = count_reg;
    assign list_empty  = (count_reg == '0);

    // checks
    `OLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT,
        "entry count above depth")
    `OLE_ASSERT_NEXT(a_exec_done, clk, rst_n, state_reg == ST_EXEC, done_reg,
        "update cycle not followed by a result beat")
    `OLE_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !done_reg,
        "accepted command did not enter the update cycle")
    `OLE_ASSERT_NOW(a_fail_keeps, clk, rst_n, done_reg && (st_reg != ST_OK),
        count_reg == $past(count_reg), "failed command changed the count")

endmodule

`default_nettype wire
